[rtl/msma_pkg.sv]
// ----------------------------------------------------------------------------
// msma_pkg
// Shared widths, gain reset values, state codes and divider status for the
// per-channel scaled moving average.
// ----------------------------------------------------------------------------
package msma_pkg;

    localparam int CODE_W    = 12;
    localparam int GAIN_W    = 24;
    localparam int PROD_W    = CODE_W + GAIN_W;
    localparam int FRAC_W    = 16;
    localparam int VAL_W     = 20;
    localparam int FILL_W    = 4;
    localparam int CH_W      = 2;
    localparam int NUM_GAINS = 4;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int S_TUSER_W = 1 + CH_W;
    localparam int S_TDATA_W = 16;
    localparam int M_TUSER_W = CH_W;
    localparam int M_TDATA_W = 24;

    // output volt, input volt, output current, input current
    localparam logic [GAIN_W-1:0] GAIN_RESET [NUM_GAINS] = '{
        24'd1003445, 24'd258783, 24'd211252, 24'd528129
    };

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_UPD  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[rtl/msma_div.sv]
// ----------------------------------------------------------------------------
// msma_div
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module msma_div #(
    parameter int DW = 24,
    parameter int NW = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DW-1:0]         i_dividend,
    input  logic [NW-1:0]         i_divisor,
    output msma_pkg::t_div_stat   o_stat,
    output logic [DW-1:0]         o_quotient
);
    import msma_pkg::*;

    localparam int STEPS = DW / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_dsr;

    logic [NW:0]   trial1;
    logic [NW:0]   trial2;
    logic [NW-1:0] rem1;
    logic [NW-1:0] n_rem;
    logic          q1;
    logic          q2;
    logic [DW-1:0] n_quo;

    always_comb begin
        trial1 = {r_rem, r_quo[DW-1]};
        if (trial1 >= {1'b0, r_dsr}) begin
            rem1 = NW'(trial1 - {1'b0, r_dsr});
            q1   = 1'b1;
        end else begin
            rem1 = trial1[NW-1:0];
            q1   = 1'b0;
        end
        trial2 = {rem1, r_quo[DW-2]};
        if (trial2 >= {1'b0, r_dsr}) begin
            n_rem = NW'(trial2 - {1'b0, r_dsr});
            q2    = 1'b1;
        end else begin
            n_rem = trial2[NW-1:0];
            q2    = 1'b0;
        end
        n_quo = {r_quo[DW-3:0], q1, q2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

[rtl/multichannel_scaled_moving_average_top.sv]
// ----------------------------------------------------------------------------
// multichannel_scaled_moving_average_top
// Per-channel scaled moving average of converter codes.
// ----------------------------------------------------------------------------
// Each filter word scales a 12-bit code by its channel's Q16 gain, stores it
// in that channel's ring of the last WINDOW samples and returns the floor
// mean of the samples held so far with their count. A clear word empties all
// channels when it is accepted and returns nothing. One word is processed at a
// time: a filter word passes the multiply, update, divide and output states
// before the next word is taken, the divide run by the two-bit-a-cycle divider
// behind the running-sum update of the sample memory. A finished result waits in
// the output register while the next word is taken.
// ----------------------------------------------------------------------------
module multichannel_scaled_moving_average_top #(
    parameter int WINDOW   = 10,
    parameter int CHANNELS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tuser: mode[0], channel[2:1]
    input  logic [msma_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // tdata: sample_code[11:0], zero[15:12]
    input  logic [msma_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tuser: out_channel[1:0]
    output logic [msma_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    // tdata: average[19:0], fill[23:20]
    output logic [msma_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [msma_pkg::PADDR_W-1:0]    paddr,
    input  logic [msma_pkg::PDATA_W-1:0]    pwdata,
    output logic [msma_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import msma_pkg::*;

    localparam int SUMW  = VAL_W + $clog2(WINDOW);
    localparam int DW    = SUMW + (SUMW % 2);
    localparam int NW    = $clog2(WINDOW + 1);
    localparam int SW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state            r_state;
    logic [GAIN_W-1:0] r_gain [NUM_GAINS];
    logic [SW-1:0]     r_slot [CHANNELS];
    logic [NW-1:0]     r_fill [CHANNELS];
    logic [SUMW-1:0]   r_sum  [CHANNELS];
    logic [VAL_W-1:0]  r_ring [DEPTH];
    logic [VAL_W-1:0]  r_ring_rd;

    logic [CH_W-1:0]   r_ch;
    logic              r_built;
    logic [CODE_W-1:0] r_code;
    logic [VAL_W-1:0]  r_scaled;
    logic [AW-1:0]     r_addr;
    logic [NW-1:0]     r_n;

    logic              r_out_valid;
    logic [CH_W-1:0]   r_out_ch;
    logic [VAL_W-1:0]  r_out_avg;
    logic [FILL_W-1:0] r_out_fill;

    logic              s_acc;
    logic              cfg_wr;
    logic              out_load;
    logic [CIW-1:0]    ch_idx;
    logic [AW-1:0]     n_addr;
    logic [PROD_W-1:0] prod;
    logic [SUMW-1:0]   cur_sum;
    logic [SUMW-1:0]   n_sum;
    logic [SW-1:0]     n_slot;
    logic [NW-1:0]     n_fill;
    logic              div_start;
    logic [DW-1:0]     div_dividend;
    logic [NW-1:0]     div_divisor;
    t_div_stat         div_stat;
    logic [DW-1:0]     div_quo;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);
    assign ch_idx   = CIW'(r_ch);

    always_comb begin
        n_addr = AW'(int'(r_ch) * WINDOW + int'(r_slot[ch_idx]));
        prod   = PROD_W'(r_code) * PROD_W'(r_gain[r_ch]);

        cur_sum = (r_fill[ch_idx] == '0) ? '0 : r_sum[ch_idx];
        if (r_fill[ch_idx] == NW'(WINDOW)) begin
            n_sum  = cur_sum + SUMW'(r_scaled) - SUMW'(r_ring_rd);
            n_fill = r_fill[ch_idx];
        end else begin
            n_sum  = cur_sum + SUMW'(r_scaled);
            n_fill = r_fill[ch_idx] + 1'b1;
        end
        n_slot = (r_slot[ch_idx] == SW'(WINDOW - 1)) ? '0 : r_slot[ch_idx] + 1'b1;

        div_start    = (r_state == S_UPD);
        div_dividend = r_built ? DW'(n_sum) : DW'(r_scaled);
        div_divisor  = r_built ? n_fill : NW'(1);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_GAINS; g++) begin
                r_gain[g] <= GAIN_RESET[g];
            end
        end else if (cfg_wr) begin
            r_gain[paddr[3:2]] <= pwdata[GAIN_W-1:0];
        end
    end

    assign prdata = PDATA_W'(r_gain[paddr[3:2]]);
    assign pready = 1'b1;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_slot[c] <= '0;
                r_fill[c] <= '0;
            end
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        if (s_axis_tuser[0]) begin
                            for (int c = 0; c < CHANNELS; c++) begin
                                r_slot[c] <= '0;
                                r_fill[c] <= '0;
                            end
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: r_state <= S_UPD;
                S_UPD: begin
                    if (r_built) begin
                        r_slot[ch_idx] <= n_slot;
                        r_fill[ch_idx] <= n_fill;
                    end
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_ch    <= s_axis_tuser[2:1];
            r_built <= (int'(s_axis_tuser[2:1]) < CHANNELS);
            r_code  <= s_axis_tdata[CODE_W-1:0];
        end
        if (r_state == S_MUL) begin
            r_scaled <= prod[PROD_W-1:FRAC_W];
            r_addr   <= n_addr;
        end
        if (r_state == S_UPD) begin
            r_n <= div_divisor;
            if (r_built) begin
                r_sum[ch_idx] <= n_sum;
            end
        end
        if (out_load) begin
            r_out_ch   <= r_ch;
            r_out_avg  <= div_quo[VAL_W-1:0];
            r_out_fill <= FILL_W'(r_n);
        end
    end

    // sample memory
    always_ff @(posedge i_clk) begin
        if ((r_state == S_UPD) && r_built) begin
            r_ring[r_addr] <= r_scaled;
        end
        r_ring_rd <= r_ring[n_addr];
    end

    msma_div #(
        .DW (DW),
        .NW (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_ch;
    assign m_axis_tdata  = {r_out_fill, r_out_avg};

`ifndef SYNTHESIS
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_n != '0))
        else $error("divide started with zero divisor");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPD) && r_built) |-> (r_fill[ch_idx] <= NW'(WINDOW)))
        else $error("fill count beyond window");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> !s_axis_tready)
        else $error("word accepted while divide in progress");
`endif

endmodule

[tb/tb_multichannel_scaled_moving_average_top.sv]
// ----------------------------------------------------------------------------
// tb_multichannel_scaled_moving_average_top
// Self-checking bench for the per-channel scaled moving average.
// ----------------------------------------------------------------------------
// Drives filter and clear words into the slave stream and programs the four
// gain registers over APB between phases. A local predictor keeps its own
// gains, sample rings, write slots and fill counts, and queues one expected
// average per filter word. Every result word is compared field by field with
// the oldest queued average. Random gaps on the sender and random stalls on
// the receiver run alongside directed checks of code and gain extremes, ring
// wrap past the window and clear words.
// ----------------------------------------------------------------------------
module tb_multichannel_scaled_moving_average_top;
    import msma_pkg::*;

    localparam int WINDOW          = 10;
    localparam int CHANNELS        = 4;
    localparam int SETTLE_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int RANDOM_PHASES   = 6;
    localparam int WORDS_PER_PHASE = 96;
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
    localparam logic [CODE_W-1:0] CODE_MAX = '1;

    typedef enum logic {
        MODE_FILTER = 1'b0,
        MODE_CLEAR  = 1'b1
    } word_mode_e;

    typedef enum logic [1:0] {
        GAIN_OUT_VOLT = 2'd0,
        GAIN_IN_VOLT  = 2'd1,
        GAIN_OUT_CURR = 2'd2,
        GAIN_IN_CURR  = 2'd3
    } gain_reg_e;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [VAL_W-1:0]  average;
        logic [FILL_W-1:0] fill;
    } channel_average_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    logic [VAL_W-1:0]     ring_model [CHANNELS][WINDOW];
    int unsigned          slot_model [CHANNELS];
    int unsigned          fill_model [CHANNELS];
    logic [GAIN_W-1:0]    gain_model [NUM_GAINS];
    channel_average_t     pending_averages [$];

    int unsigned          mismatch_count;
    int unsigned          idle_cycles;
    int unsigned          stall_left;
    bit                   tx_idle_on;
    bit                   rx_idle_on;

    multichannel_scaled_moving_average_top #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned pick_gap(bit enabled);
        int unsigned roll;
        if (!enabled) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic void compute_moving_average(word_mode_e mode, logic [CH_W-1:0] ch,
                                                   logic [CODE_W-1:0] code);
        logic [PROD_W-1:0] product;
        int unsigned       total;
        channel_average_t  result;
        if (mode == MODE_CLEAR) begin
            foreach (slot_model[c]) begin
                slot_model[c] = 0;
                fill_model[c] = 0;
            end
            return;
        end
        product = PROD_W'(code) * PROD_W'(gain_model[ch]);
        ring_model[ch][slot_model[ch]] = product[FRAC_W +: VAL_W];
        slot_model[ch] = (slot_model[ch] + 1) % WINDOW;
        if (fill_model[ch] < WINDOW) begin
            fill_model[ch]++;
        end
        total = 0;
        for (int i = 0; i < fill_model[ch]; i++) begin
            total += ring_model[ch][i];
        end
        result.channel = ch;
        result.average = VAL_W'(total / fill_model[ch]);
        result.fill    = FILL_W'(fill_model[ch]);
        pending_averages.push_back(result);
    endfunction

    // hold each word until taken, then log its expected average
    task automatic send_word(word_mode_e mode, logic [CH_W-1:0] ch, logic [CODE_W-1:0] code);
        int unsigned gap;
        gap = pick_gap(tx_idle_on);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {ch, mode};
        s_axis_tdata  <= S_TDATA_W'(code);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        compute_moving_average(mode, ch, code);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_averages.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_gain(gain_reg_e idx, logic [GAIN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        gain_model[idx] = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_gains(logic [GAIN_W-1:0] g_out_volt, logic [GAIN_W-1:0] g_in_volt,
                              logic [GAIN_W-1:0] g_out_curr, logic [GAIN_W-1:0] g_in_curr);
        drain_results();
        write_gain(GAIN_OUT_VOLT, g_out_volt);
        write_gain(GAIN_IN_VOLT, g_in_volt);
        write_gain(GAIN_OUT_CURR, g_out_curr);
        write_gain(GAIN_IN_CURR, g_in_curr);
    endtask

    task automatic test_default_gains();
        for (int c = 0; c < CHANNELS; c++) begin
            send_word(MODE_FILTER, CH_W'(c), '0);
            send_word(MODE_FILTER, CH_W'(c), CODE_MAX);
        end
    endtask

    // run past the window so the fill saturates and the ring wraps
    task automatic test_window_wrap();
        for (int w = 0; w <= WINDOW; w++) begin
            send_word(MODE_FILTER, CH_W'(2), CODE_W'($urandom_range(0, CODE_MAX)));
        end
    endtask

    task automatic test_clear();
        send_word(MODE_CLEAR, CH_W'(3), CODE_MAX);
        send_word(MODE_CLEAR, CH_W'(0), '0);
        send_word(MODE_FILTER, CH_W'(0), CODE_MAX);
    endtask

    task automatic test_gain_extremes();
        load_gains(GAIN_MAX, '0, GAIN_MAX, '0);
        send_word(MODE_FILTER, CH_W'(0), CODE_MAX);
        send_word(MODE_FILTER, CH_W'(1), CODE_MAX);
        send_word(MODE_FILTER, CH_W'(2), '0);
    endtask

    task automatic send_random_word();
        int unsigned       roll;
        logic [CH_W-1:0]   ch;
        logic [CODE_W-1:0] code;
        ch   = CH_W'($urandom_range(0, CHANNELS - 1));
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            code = '0;
        end else if (roll == 1) begin
            code = CODE_MAX;
        end else begin
            code = CODE_W'($urandom_range(0, CODE_MAX));
        end
        if ($urandom_range(0, 99) < 3) begin
            send_word(MODE_CLEAR, ch, code);
        end else begin
            send_word(MODE_FILTER, ch, code);
        end
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
                    tx_idle_on = 1'b0;
                    rx_idle_on = 1'b0;
                end
                1: begin
                    load_gains('0, '0, '0, '0);
                    tx_idle_on = 1'b1;
                    rx_idle_on = 1'b0;
                end
                2: begin
                    load_gains(GAIN_RESET[0], GAIN_RESET[1], GAIN_RESET[2], GAIN_RESET[3]);
                    tx_idle_on = 1'b0;
                    rx_idle_on = 1'b1;
                end
                default: begin
                    load_gains(GAIN_W'($urandom_range(0, GAIN_MAX)),
                               GAIN_W'($urandom_range(0, GAIN_MAX)),
                               GAIN_W'($urandom_range(0, GAIN_MAX)),
                               GAIN_W'($urandom_range(0, GAIN_MAX)));
                    tx_idle_on = 1'b1;
                    rx_idle_on = 1'b1;
                end
            endcase
            for (int w = 0; w < WORDS_PER_PHASE; w++) begin
                if (w == WORDS_PER_PHASE / 2 || $urandom_range(0, 99) == 0) begin
                    drain_results();
                end
                send_random_word();
            end
        end
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap(rx_idle_on);
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        channel_average_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_averages.size() == 0) begin
                $error("result word with nothing pending: tuser %0d tdata 0x%06h",
                       m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_averages.pop_front();
                if (m_axis_tuser != want.channel) begin
                    $error("out_channel expected %0d got %0d", want.channel, m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tdata[VAL_W-1:0] != want.average) begin
                    $error("average expected %0d got %0d", want.average,
                           m_axis_tdata[VAL_W-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[VAL_W +: FILL_W] != want.fill) begin
                    $error("fill expected %0d got %0d", want.fill,
                           m_axis_tdata[VAL_W +: FILL_W]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        foreach (gain_model[r]) begin
            gain_model[r] = GAIN_RESET[r];
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_gains();
        test_window_wrap();
        test_clear();
        test_gain_extremes();
        test_random_traffic();
        drain_results();

        if (mismatch_count == 0 && pending_averages.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
